[rtl/trd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trd_pkg
// Shared request/result types and mode codes for the triangle rasterizer.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam logic [2:0] MODE_DRAW      = 3'd0;
  localparam logic [2:0] MODE_CLR_COLOR = 3'd1;
  localparam logic [2:0] MODE_CLR_DEPTH = 3'd2;
  localparam logic [2:0] MODE_CLR_BOTH  = 3'd3;
  localparam logic [2:0] MODE_READ      = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [11:0] vertex_0_x;
    logic signed [11:0] vertex_0_y;
    logic [15:0]        vertex_0_z;
    logic signed [11:0] vertex_1_x;
    logic signed [11:0] vertex_1_y;
    logic [15:0]        vertex_1_z;
    logic signed [11:0] vertex_2_x;
    logic signed [11:0] vertex_2_y;
    logic [15:0]        vertex_2_z;
    logic [23:0]        fill_color;
    logic [1:0]         sample_select;
  } req_t;

  typedef struct packed {
    logic [23:0] pixel_color;
    logic [15:0] pixel_depth;
    logic [12:0] pixels_written;
  } rsp_t;

endpackage
`default_nettype wire

[rtl/triangle_raster_depth_msaa.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_raster_depth_msaa
// Edge-function triangle rasterizer with depth test and 2x2 multisampling.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass fills the stores
// before the first request is taken; a clear request runs the same pass.
// A draw visits every pixel of the clipped bounding box one sample at a
// time; each sample takes its edge products on one shared multiplier, a
// sample inside the triangle then the depth numerator and a serial depth
// divider for a 17-bit quotient; a sample outside skips the depth work.
// The result waits in an output register until taken.
module triangle_raster_depth_msaa #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            sample_mode_we,
  input  wire logic            sample_mode_wdata,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire trd_pkg::req_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output trd_pkg::rsp_t        out_data
);
  import trd_pkg::*;

  localparam int XW  = $clog2(SCREEN_WIDTH);
  localparam int YW  = $clog2(SCREEN_HEIGHT);
  localparam int PAW = XW + YW;
  localparam int SAW = PAW + 2;
  localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int SMP = 4 * PIX;

  typedef enum logic [12:0] {
    S_INIT   = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_CLEAR  = 13'b0000000000100,
    S_BOX    = 13'b0000000001000,
    S_PROBE  = 13'b0000000010000,
    S_MUL    = 13'b0000000100000,
    S_EDGE   = 13'b0000001000000,
    S_ZMUL   = 13'b0000010000000,
    S_DIV    = 13'b0000100000000,
    S_TEST   = 13'b0001000000000,
    S_PIXEND = 13'b0010000000000,
    S_READ   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state;
  logic   sample_mode;
  req_t   req;

  // stores
  logic [23:0] color_mem [PIX];
  logic [15:0] pdepth_mem [PIX];
  logic [15:0] sdepth_mem [SMP];
  logic [23:0] color_rd;
  logic [15:0] pdepth_rd, sdepth_rd;
  logic [PAW-1:0] pix_ra, pix_wa;
  logic [SAW-1:0] smp_ra, smp_wa;
  logic        color_we, pdepth_we, sdepth_we;
  logic [23:0] color_wd;
  logic [15:0] pdepth_wd, sdepth_wd;

  always_ff @(posedge clk) begin
    if (color_we) color_mem[pix_wa] <= color_wd;
    color_rd <= color_mem[pix_ra];
  end
  always_ff @(posedge clk) begin
    if (pdepth_we) pdepth_mem[pix_wa] <= pdepth_wd;
    pdepth_rd <= pdepth_mem[pix_ra];
  end
  always_ff @(posedge clk) begin
    if (sdepth_we) sdepth_mem[smp_wa] <= sdepth_wd;
    sdepth_rd <= sdepth_mem[smp_ra];
  end

  // scan registers
  logic [SAW:0]   clr_cnt;
  logic           clr_color, clr_depth;
  logic [XW-1:0]  px, bx0, bx1;
  logic [YW-1:0]  py, by0, by1;
  logic [1:0]     smp;
  logic [2:0]     passed;
  logic [12:0]    written;
  logic [2:0]     step;
  logic signed [26:0] prod [6];
  logic signed [27:0] ed [3];
  logic [39:0]    dsum;
  logic [55:0]    znum;
  logic [15:0]    zval;
  logic [23:0]    scaled;

  // sample position in 1/16 pixel
  logic signed [13:0] spx, spy;
  always_comb begin
    if (sample_mode) begin
      spx = 14'(signed'({1'b0, px, 4'd0})) + (smp[0] ? 14'sd12 : 14'sd4);
      spy = 14'(signed'({1'b0, py, 4'd0})) + (smp[1] ? 14'sd12 : 14'sd4);
    end else begin
      spx = 14'(signed'({1'b0, px, 4'd0})) + 14'sd8;
      spy = 14'(signed'({1'b0, py, 4'd0})) + 14'sd8;
    end
  end

  // shared multiplier operands, one edge product per step
  logic signed [13:0] ma, mb;
  logic signed [12:0] vx0, vx1, vx2, vy0, vy1, vy2;
  assign vx0 = 13'(req.vertex_0_x);
  assign vx1 = 13'(req.vertex_1_x);
  assign vx2 = 13'(req.vertex_2_x);
  assign vy0 = 13'(req.vertex_0_y);
  assign vy1 = 13'(req.vertex_1_y);
  assign vy2 = 13'(req.vertex_2_y);
  always_comb begin
    unique case (step)
      3'd0: begin ma = 14'(vx1 - vx0); mb = spy - 14'(vy0); end
      3'd1: begin ma = 14'(vy1 - vy0); mb = spx - 14'(vx0); end
      3'd2: begin ma = 14'(vx2 - vx1); mb = spy - 14'(vy1); end
      3'd3: begin ma = 14'(vy2 - vy1); mb = spx - 14'(vx1); end
      3'd4: begin ma = 14'(vx0 - vx2); mb = spy - 14'(vy2); end
      default: begin ma = 14'(vy0 - vy2); mb = spx - 14'(vx2); end
    endcase
  end

  // edge signs
  logic pos, neg;
  assign pos = ed[0] > 0 && ed[1] > 0 && ed[2] > 0;
  assign neg = ed[0] < 0 && ed[1] < 0 && ed[2] < 0;

  // depth numerator, one weight times z per step
  logic [27:0] w_sel;
  logic [15:0] z_sel;
  always_comb begin
    unique case (step[1:0])
      2'd0:    begin w_sel = 28'(ed[1]); z_sel = req.vertex_0_z; end
      2'd1:    begin w_sel = 28'(ed[2]); z_sel = req.vertex_1_z; end
      default: begin w_sel = 28'(ed[0]); z_sel = req.vertex_2_z; end
    endcase
  end
  logic [43:0] zprod;
  always_ff @(posedge clk) zprod <= w_sel * z_sel;

  logic        div_start, div_done;
  logic [16:0] div_q;
  trd_divider #(.NumW(57), .DenW(41), .QW(17)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({znum, 1'b0} + 57'(dsum)),
    .den   ({dsum, 1'b0}),
    .done  (div_done),
    .quot  (div_q)
  );

  // bounding box in pixels
  logic signed [12:0] mnx, mxx, mny, mxy;
  logic signed [8:0]  fx0, fx1, fy0, fy1;
  always_comb begin
    mnx = vx0; mxx = vx0; mny = vy0; mxy = vy0;
    if (vx1 < mnx) mnx = vx1;
    if (vx2 < mnx) mnx = vx2;
    if (vx1 > mxx) mxx = vx1;
    if (vx2 > mxx) mxx = vx2;
    if (vy1 < mny) mny = vy1;
    if (vy2 < mny) mny = vy2;
    if (vy1 > mxy) mxy = vy1;
    if (vy2 > mxy) mxy = vy2;
    fx0 = 9'(mnx >>> 4);
    fy0 = 9'(mny >>> 4);
    fx1 = 9'((mxx + 13'sd15) >>> 4);
    fy1 = 9'((mxy + 13'sd15) >>> 4);
  end

  // colour scaled by passed count
  always_comb begin
    scaled[23:16] = 8'((11'(req.fill_color[23:16]) * 11'(passed)) >> 2);
    scaled[15:8]  = 8'((11'(req.fill_color[15:8])  * 11'(passed)) >> 2);
    scaled[7:0]   = 8'((11'(req.fill_color[7:0])   * 11'(passed)) >> 2);
  end

  // addresses
  logic [SAW-1:0] smp_addr;
  assign smp_addr = SAW'({py, smp[1]}) * SAW'(2 * SCREEN_WIDTH) + SAW'({px, smp[0]});
  always_comb begin
    pix_wa = PAW'(py) * PAW'(SCREEN_WIDTH) + PAW'(px);
    smp_wa = smp_addr;
    color_we = 1'b0; pdepth_we = 1'b0; sdepth_we = 1'b0;
    color_wd = req.fill_color; pdepth_wd = zval; sdepth_wd = zval;
    if (state == S_CLEAR || state == S_INIT) begin
      pix_wa   = clr_cnt[PAW-1:0];
      smp_wa   = clr_cnt[SAW-1:0];
      color_wd = '0; pdepth_wd = 16'hFFFF; sdepth_wd = 16'hFFFF;
      color_we  = clr_color && clr_cnt < (SAW+1)'(PIX);
      pdepth_we = clr_depth && clr_cnt < (SAW+1)'(PIX);
      sdepth_we = clr_depth;
    end else if (state == S_TEST) begin
      if (sample_mode) begin
        sdepth_we = zval < sdepth_rd;
      end else begin
        pdepth_we = zval < pdepth_rd;
        color_we  = zval < pdepth_rd;
      end
    end else if (state == S_PIXEND) begin
      color_we = sample_mode && passed != 3'd0;
      color_wd = scaled;
    end
  end
  assign pix_ra = pix_wa;
  assign smp_ra = smp_addr;

  logic rd_ok;
  assign rd_ok = req.vertex_0_x >= 0 && req.vertex_0_x < 12'(SCREEN_WIDTH)
              && req.vertex_0_y >= 0 && req.vertex_0_y < 12'(SCREEN_HEIGHT);

  assign in_ready = state == S_IDLE;
  assign div_start = state == S_ZMUL && step == 3'd3;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) sample_mode <= 1'b1;
    else if (sample_mode_we) sample_mode <= sample_mode_wdata;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr_cnt   <= '0;
      clr_color <= 1'b1;
      clr_depth <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_INIT, S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (SAW+1)'(SMP - 1)) begin
            if (state == S_INIT) begin
              state <= S_IDLE;
            end else begin
              state <= S_DONE;
              out_valid <= 1'b1;
            end
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req      <= in_data;
            out_data <= '0;
            written  <= '0;
            clr_cnt  <= '0;
            clr_color <= in_data.mode[0];
            clr_depth <= in_data.mode[1];
            priority case (1'b1)
              in_data.mode == MODE_DRAW: state <= S_BOX;
              in_data.mode == MODE_CLR_COLOR || in_data.mode == MODE_CLR_DEPTH
                || in_data.mode == MODE_CLR_BOTH: state <= S_CLEAR;
              in_data.mode == MODE_READ: begin
                state <= S_READ;
                step  <= '0;
              end
              default: begin
                state <= S_DONE;
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          px  <= XW'(req.vertex_0_x);
          py  <= YW'(req.vertex_0_y);
          smp <= req.sample_select;
          step <= step + 1'b1;
          if (step == 3'd2) begin
            if (rd_ok) begin
              out_data.pixel_color <= color_rd;
              out_data.pixel_depth <= sample_mode ? sdepth_rd : pdepth_rd;
            end
            state <= S_DONE;
            out_valid <= 1'b1;
          end
        end
        S_BOX: begin
          if (fx0 > 9'(SCREEN_WIDTH - 1) || fy0 > 9'(SCREEN_HEIGHT - 1)
              || fx1 < 0 || fy1 < 0) begin
            state <= S_DONE;
            out_valid <= 1'b1;
          end else begin
            bx0 <= fx0 < 0 ? '0 : XW'(fx0);
            by0 <= fy0 < 0 ? '0 : YW'(fy0);
            bx1 <= fx1 > 9'(SCREEN_WIDTH - 1) ? XW'(SCREEN_WIDTH - 1) : XW'(fx1);
            by1 <= fy1 > 9'(SCREEN_HEIGHT - 1) ? YW'(SCREEN_HEIGHT - 1) : YW'(fy1);
            px  <= fx0 < 0 ? '0 : XW'(fx0);
            py  <= fy0 < 0 ? '0 : YW'(fy0);
            smp <= '0;
            passed <= '0;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod[step] <= ma * mb;
          step <= step + 1'b1;
          if (step == 3'd5) state <= S_EDGE;
        end
        S_EDGE: begin
          ed[0] <= 28'(prod[0]) - 28'(prod[1]);
          ed[1] <= 28'(prod[2]) - 28'(prod[3]);
          ed[2] <= 28'(prod[4]) - 28'(prod[5]);
          step  <= '0;
          znum  <= '0;
          state <= S_ZMUL;
        end
        S_ZMUL: begin
          if (step == 3'd0) begin
            if (!pos && !neg) begin
              state <= S_TEST;
              zval  <= 16'hFFFF;
            end else if (neg) begin
              ed[0] <= -ed[0]; ed[1] <= -ed[1]; ed[2] <= -ed[2];
              step <= 3'd4;
            end else begin
              step <= 3'd4;
            end
          end else if (step == 3'd4) begin
            dsum <= 40'(ed[0]) + 40'(ed[1]) + 40'(ed[2]);
            step <= 3'd5;
          end else if (step == 3'd5 || step == 3'd6) begin
            step <= step + 1'b1;
          end else if (step == 3'd7) begin
            step <= 3'd3;
          end else begin
            state <= S_DIV;
          end
          if (step >= 3'd5) begin
            znum <= znum + 56'(zprod);
          end
        end
        S_DIV: begin
          if (div_done) begin
            zval  <= 16'(div_q);
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if ((pos || neg) && zval < (sample_mode ? sdepth_rd : pdepth_rd)) begin
            passed <= passed + 1'b1;
            if (!sample_mode && written != 13'h1FFF) written <= written + 1'b1;
          end
          if (sample_mode && smp != 2'd3) begin
            smp   <= smp + 1'b1;
            state <= S_PROBE;
          end else begin
            state <= S_PIXEND;
          end
        end
        S_PIXEND: begin
          if (sample_mode && passed != 3'd0 && written != 13'h1FFF)
            written <= written + 1'b1;
          passed <= '0;
          smp    <= '0;
          if (py != by1) begin
            py <= py + 1'b1;
            state <= S_PROBE;
          end else if (px != bx1) begin
            py <= by0;
            px <= px + 1'b1;
            state <= S_PROBE;
          end else begin
            // final count, including this pixel
            out_data.pixels_written <= (sample_mode && passed != 3'd0 && written != 13'h1FFF)
                                       ? written + 1'b1 : written;
            state <= S_DONE;
            out_valid <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/trd_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trd_divider
// Restoring divider, one quotient bit per cycle: q = num / den.
// ----------------------------------------------------------------------------
module trd_divider #(
  parameter int NumW = 56,
  parameter int DenW = 40,
  parameter int QW   = 17
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [QW-1:0]        quot
);
  localparam int CW = $clog2(QW + 1);
  logic [DenW:0]   rem;
  logic [NumW-1:0] sh;
  logic [DenW-1:0] dv;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [DenW:0]   trial;

  // shift in next numerator bit
  assign trial = {rem[DenW-1:0], sh[NumW-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      // high numerator part is below den since the quotient fits in QW bits
      rem  <= (DenW+1)'(num >> QW);
      sh   <= num << (NumW - QW);
      dv   <= den;
      cnt  <= CW'(QW);
      quot <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, dv}) begin
        rem  <= trial - {1'b0, dv};
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[QW-2:0], 1'b0};
      end
      sh  <= sh << 1;
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire
